// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IOPB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("iopb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IOPB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("iopb assertion failed");

`endif

// ===== hw/rtl/iopb_pkg.sv =====
// Package: sizes, operation codes and shared types of the I/O permission bitmap.
`timescale 1ns / 1ps
package iopb_pkg;

  localparam int unsigned MAP_BYTES = 8192;
  localparam int unsigned MAP_WORDS = (MAP_BYTES + 7) / 8;
  localparam int unsigned MAP_PORTS = MAP_BYTES * 8;

  localparam int unsigned PORT_W    = 16;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_W     = 6;
  localparam int unsigned WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  localparam logic [PORT_W:0]       MAP_PORTS_X   = (PORT_W + 1)'(MAP_PORTS);
  localparam logic [PORT_W-1:0]     MAP_LAST_PORT = PORT_W'(MAP_PORTS - 1);
  localparam logic [WORD_AW-1:0]    LAST_WORD     = WORD_AW'(MAP_WORDS - 1);
  localparam logic [BIT_W-1:0]      TOP_BIT       = BIT_W'(WORD_BITS - 1);

  localparam logic [1:0] OP_ALLOW    = 2'd0;
  localparam logic [1:0] OP_DENY     = 2'd1;
  localparam logic [1:0] OP_DENY_ALL = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  typedef struct packed {
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

endpackage

// ===== hw/rtl/iopb_if.sv =====
// Channel interfaces: request and result transactions with valid/ready.
`timescale 1ns / 1ps
interface iopb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] first_port;
  logic [15:0] last_port;

  modport source (output valid, output operation, output first_port, output last_port,
                  input ready);
  modport sink   (input valid, input operation, input first_port, input last_port,
                  output ready);
endinterface

interface iopb_out_if;
  logic valid;
  logic ready;
  logic port_allowed;
  logic range_empty;

  modport source (output valid, output port_allowed, output range_empty, input ready);
  modport sink   (input valid, input port_allowed, input range_empty, output ready);
endinterface

// ===== hw/rtl/io_permission_bitmap.sv =====
// Top level: I/O permission bitmap with one deny bit per port and a word sequencer.
//
// Usage: in_chan carries one request transaction (operation, first_port, last_port);
//   out_chan returns exactly one result transaction per request: port_allowed
//   (queries only) and range_empty (reversed ranges only). Ports are 16 bits;
//   ports at or past MAP_BYTES*8 have no bit, are left alone by allow/deny and
//   always answer denied.
// Sequence, from the accepted request to out_chan.valid via HOLD and the output register
//   query                     : QREAD (address, registered read), QBIT (result), HOLD
//   allow/deny range of n words: RANGE, one read-modify-write per word, then DRAIN, HOLD
//   reversed or off-map range : straight to HOLD
//   deny all                  : FILL writes all MAP_WORDS words, then HOLD
//   One word unit serves every word; the memory has one write and one read port;
//   in_chan.ready is high only while the sequencer is idle.
// Reset: rst_n (synchronous, active low) starts a fill pass writing all ones,
//   one word per cycle through all MAP_WORDS words (1024 at full size); no request is
//   taken until it ends, after which every port is denied.
// Stalls: a result sits in the output register until out_chan.ready; a new
//   request may still be accepted meanwhile, and its own result waits until
//   the slot frees.
`timescale 1ns / 1ps
module io_permission_bitmap (
  input  logic       clk,
  input  logic       rst_n,
  iopb_in_if.sink    in_chan,
  iopb_out_if.source out_chan
);
  import iopb_pkg::*;

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_FILL  = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd2;
  localparam logic [ST_W-1:0] ST_DRAIN = 3'd3;
  localparam logic [ST_W-1:0] ST_QREAD = 3'd4;
  localparam logic [ST_W-1:0] ST_QBIT  = 3'd5;
  localparam logic [ST_W-1:0] ST_HOLD  = 3'd6;

  logic [ST_W-1:0]    state_r, state_nxt;
  logic [WORD_AW-1:0] cur_r, cur_nxt;       // word being swept
  logic [WORD_AW-1:0] end_r, end_nxt;       // last word of the range
  logic [PORT_W-1:0]  lo_port_r, lo_port_nxt;
  logic [PORT_W-1:0]  hi_port_r, hi_port_nxt;
  logic               deny_r, deny_nxt;
  logic               fill_op_r, fill_op_nxt;   // fill came from deny all, not reset
  logic               pend_r, pend_nxt;         // read data due for write-back
  logic [WORD_AW-1:0] pend_idx_r, pend_idx_nxt;
  logic               in_map_r, in_map_nxt;
  logic               res_allowed_r, res_allowed_nxt;
  logic               res_empty_r, res_empty_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_allowed_r, out_allowed_nxt;
  logic               out_empty_r, out_empty_nxt;

  logic                 in_accept;
  logic                 first_in_map;
  logic                 last_in_map;
  logic [PORT_W-1:0]    hi_clamped;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] merged_word;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_accept     = in_chan.valid & in_chan.ready;

  assign first_in_map = ({1'b0, in_chan.first_port} < MAP_PORTS_X);
  assign last_in_map  = ({1'b0, in_chan.last_port} < MAP_PORTS_X);
  assign hi_clamped   = last_in_map ? in_chan.last_port : MAP_LAST_PORT;

  iopb_mem u_mem (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (rd_word)
  );

  // one word of the range per cycle, written back the cycle after its read
  iopb_word_unit u_word (
    .word_idx (pend_idx_r),
    .lo_port  (lo_port_r),
    .hi_port  (hi_port_r),
    .deny     (deny_r),
    .old_word (rd_word),
    .new_word (merged_word)
  );

  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    end_nxt         = end_r;
    lo_port_nxt     = lo_port_r;
    hi_port_nxt     = hi_port_r;
    deny_nxt        = deny_r;
    fill_op_nxt     = fill_op_r;
    pend_nxt        = pend_r;
    pend_idx_nxt    = pend_idx_r;
    in_map_nxt      = in_map_r;
    res_allowed_nxt = res_allowed_r;
    res_empty_nxt   = res_empty_r;
    mem_req         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_allowed_nxt = 1'b0;
          res_empty_nxt   = 1'b0;
          unique case (in_chan.operation)
            OP_ALLOW, OP_DENY: begin
              deny_nxt = (in_chan.operation == OP_DENY);
              if (in_chan.first_port > in_chan.last_port) begin
                res_empty_nxt = 1'b1;
                state_nxt     = ST_HOLD;
              end else if (!first_in_map) begin
                // whole range past the end of the map
                state_nxt = ST_HOLD;
              end else begin
                lo_port_nxt = in_chan.first_port;
                hi_port_nxt = hi_clamped;
                cur_nxt     = WORD_AW'(in_chan.first_port[PORT_W-1:BIT_W]);
                end_nxt     = WORD_AW'(hi_clamped[PORT_W-1:BIT_W]);
                pend_nxt    = 1'b0;
                state_nxt   = ST_RANGE;
              end
            end
            OP_DENY_ALL: begin
              cur_nxt     = '0;
              fill_op_nxt = 1'b1;
              state_nxt   = ST_FILL;
            end
            OP_QUERY: begin
              lo_port_nxt = in_chan.first_port;
              in_map_nxt  = first_in_map;
              state_nxt   = ST_QREAD;
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cur_r;
        mem_req.wr_data = '1;
        if (cur_r == LAST_WORD) begin
          res_allowed_nxt = 1'b0;
          res_empty_nxt   = 1'b0;
          state_nxt       = fill_op_r ? ST_HOLD : ST_IDLE;
        end else begin
          cur_nxt = cur_r + WORD_AW'(1);
        end
      end
      ST_RANGE: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = cur_r;
        mem_req.wr_en   = pend_r;
        mem_req.wr_addr = pend_idx_r;
        mem_req.wr_data = merged_word;
        pend_nxt        = 1'b1;
        pend_idx_nxt    = cur_r;
        if (cur_r == end_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          cur_nxt = cur_r + WORD_AW'(1);
        end
      end
      ST_DRAIN: begin
        mem_req.wr_en   = pend_r;
        mem_req.wr_addr = pend_idx_r;
        mem_req.wr_data = merged_word;
        pend_nxt        = 1'b0;
        state_nxt       = ST_HOLD;
      end
      ST_QREAD: begin
        mem_req.rd_en   = in_map_r;
        mem_req.rd_addr = WORD_AW'(lo_port_r[PORT_W-1:BIT_W]);
        state_nxt       = ST_QBIT;
      end
      ST_QBIT: begin
        res_allowed_nxt = in_map_r & ~rd_word[lo_port_r[BIT_W-1:0]];
        res_empty_nxt   = 1'b0;
        state_nxt       = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register: loads from HOLD once the slot is free
  always_comb begin
    out_valid_nxt   = out_valid_r & ~out_chan.ready;
    out_allowed_nxt = out_allowed_r;
    out_empty_nxt   = out_empty_r;
    if (state_r == ST_HOLD && (!out_valid_r || out_chan.ready)) begin
      out_valid_nxt   = 1'b1;
      out_allowed_nxt = res_allowed_r;
      out_empty_nxt   = res_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cur_r       <= '0;
      fill_op_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      fill_op_r   <= fill_op_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r         <= end_nxt;
    lo_port_r     <= lo_port_nxt;
    hi_port_r     <= hi_port_nxt;
    deny_r        <= deny_nxt;
    pend_idx_r    <= pend_idx_nxt;
    in_map_r      <= in_map_nxt;
    res_allowed_r <= res_allowed_nxt;
    res_empty_r   <= res_empty_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_empty_r   <= out_empty_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.port_allowed = out_allowed_r;
  assign out_chan.range_empty  = out_empty_r;

endmodule

// ===== hw/rtl/iopb_word_unit.sv =====
// Shared word unit: builds the port mask for one bitmap word and merges it.
`timescale 1ns / 1ps
module iopb_word_unit (
  input  logic [iopb_pkg::WORD_AW-1:0]   word_idx,
  input  logic [iopb_pkg::PORT_W-1:0]    lo_port,
  input  logic [iopb_pkg::PORT_W-1:0]    hi_port,
  input  logic                           deny,
  input  logic [iopb_pkg::WORD_BITS-1:0] old_word,
  output logic [iopb_pkg::WORD_BITS-1:0] new_word
);
  import iopb_pkg::*;

  logic [WORD_AW-1:0]   lo_word;
  logic [WORD_AW-1:0]   hi_word;
  logic [BIT_W-1:0]     lo_bit;
  logic [BIT_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] mask;

  assign lo_word = WORD_AW'(lo_port[PORT_W-1:BIT_W]);
  assign hi_word = WORD_AW'(hi_port[PORT_W-1:BIT_W]);

  // inner words of the range take the whole word
  assign lo_bit = (word_idx == lo_word) ? lo_port[BIT_W-1:0] : '0;
  assign hi_bit = (word_idx == hi_word) ? hi_port[BIT_W-1:0] : TOP_BIT;

  assign mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (TOP_BIT - hi_bit));

  assign new_word = deny ? (old_word | mask) : (old_word & ~mask);

endmodule

// ===== hw/rtl/iopb_mem.sv =====
// Bitmap store: one write and one registered read per cycle.
`timescale 1ns / 1ps
module iopb_mem (
  input  logic                           clk,
  input  iopb_pkg::mem_req_t             req,
  output logic [iopb_pkg::WORD_BITS-1:0] rd_data_r
);
  import iopb_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/iopb_checker.sv =====
// Port-level checker for the I/O permission bitmap, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iopb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_port_allowed,
  input logic out_range_empty
);

  // a query never reports an empty range and a range never reports allowed
  `IOPB_ASSERT_NOW(a_result_exclusive, clk, rst_n, out_valid, !(out_port_allowed && out_range_empty))

  // one request at a time: busy right after a transaction is taken
  `IOPB_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // the fill pass after reset keeps the request side closed
  `IOPB_ASSERT_NOW(a_closed_after_reset, clk, rst_n, !$past(rst_n), !in_ready)

  // a stalled result holds
  `IOPB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_port_allowed) && $stable(out_range_empty))

endmodule

bind io_permission_bitmap iopb_checker u_iopb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_port_allowed (out_chan.port_allowed),
  .out_range_empty  (out_chan.range_empty)
);

// ===== tb/io_permission_bitmap_tb.sv =====
// Self-checking bench for the I/O permission bitmap: directed and random request transactions.
`timescale 1ns / 1ps

typedef struct {
  logic [1:0]  op;
  logic [15:0] port;
  logic        allowed;
  logic        empty;
} permit_verdict_t;

// Shadow copy of the deny map plus the queue of verdicts still owed by the block.
class permit_tracker;
  bit              deny_map [iopb_pkg::MAP_PORTS];
  permit_verdict_t pending_verdicts [$];
  int              errors;
  int              results_seen;

  function new();
    errors       = 0;
    results_seen = 0;
    deny_everything();
  endfunction

  function void deny_everything();
    foreach (deny_map[i]) deny_map[i] = 1'b1;
  endfunction

  // Called for every request transaction the block takes.
  function void note_request(logic [1:0] op, logic [15:0] first, logic [15:0] last);
    permit_verdict_t want;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     p;
    want.op      = op;
    want.port    = first;
    want.allowed = 1'b0;
    want.empty   = 1'b0;
    lo = first;
    hi = last;
    case (op)
      iopb_pkg::OP_ALLOW, iopb_pkg::OP_DENY: begin
        if (lo > hi) begin
          want.empty = 1'b1;
        end else begin
          for (p = lo; p <= hi; p++)
            if (p < iopb_pkg::MAP_PORTS) deny_map[p] = (op == iopb_pkg::OP_DENY);
        end
      end
      iopb_pkg::OP_DENY_ALL: deny_everything();
      iopb_pkg::OP_QUERY: want.allowed = (lo < iopb_pkg::MAP_PORTS) && !deny_map[lo];
    endcase
    pending_verdicts.push_back(want);
  endfunction

  // Called for every result transaction taken from the block.
  function void check_verdict(logic allowed, logic empty);
    permit_verdict_t want;
    results_seen++;
    if (pending_verdicts.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("[%0t] unexpected result %0d: port_allowed %b range_empty %b",
                 $time, results_seen, allowed, empty);
      return;
    end
    want = pending_verdicts.pop_front();
    if (allowed !== want.allowed || empty !== want.empty) begin
      errors++;
      if (errors <= 10)
        $display("[%0t] mismatch on result %0d (op %0d port %h): port_allowed exp %b got %b, range_empty exp %b got %b",
                 $time, results_seen, want.op, want.port, want.allowed, allowed,
                 want.empty, empty);
    end
  endfunction

  function int outstanding();
    return pending_verdicts.size();
  endfunction
endclass

module io_permission_bitmap_tb;
  import iopb_pkg::*;

  // Slowest legal run: ~580 transactions, each up to a full-map sweep plus the
  // longest gap and stall, plus the clear pass after reset.
  // The limit allows several times over.
  localparam int CYCLE_LIMIT  = 3_000_000;
  // Longest single operation is a full sweep of all MAP_WORDS words.
  localparam int DRAIN_CYCLES = MAP_WORDS + 80;
  // Long receiver hold-off, well past the two transactions the block can buffer.
  localparam int HOLD_CYCLES  = 400;
  localparam int SEGMENTS     = 10;
  localparam int SEG_ITEMS    = 56;

  logic clk;
  logic rst_n;

  iopb_in_if  in_chan ();
  iopb_out_if out_chan ();

  io_permission_bitmap uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  permit_tracker tracker = new();

  // Stimulus steering, written only by the stimulus process.
  bit          tx_gaps;        // random idle cycles between requests when set
  int          hold_requests;  // bumped to ask the result side for a long hold-off
  logic [15:0] hot_base;       // window that three of eight port picks land in
  logic [15:0] recent_edge;    // a boundary of the last range, for edge queries

  longint cycle_count;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Watchdog: bail out if the run overstays the limit.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL io_permission_bitmap");
    $finish;
  end

  // Pick a port: anywhere, around the hot window, around the last range edge, or an extreme.
  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 7))
      0, 1:    return 16'($urandom());
      2, 3, 4: return hot_base + 16'($urandom_range(0, 255));
      5, 6:    return recent_edge + 16'($urandom_range(0, 4)) - 16'd2;
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // Offer one request transaction and hold it until the block takes it.
  // Called at a clock edge; valid is either kept high (no gap) or dropped here,
  // so it never gets two nonblocking updates in one step.
  task automatic send_request(input logic [1:0] op, input logic [15:0] first,
                              input logic [15:0] last);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= op;
    in_chan.first_port <= first;
    in_chan.last_port  <= last;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    tracker.note_request(op, first, last);
  endtask

  // Stop offering and wait for every owed result.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    logic [1:0]  op;
    logic [15:0] first;
    logic [15:0] last;
    logic [15:0] swap;
    int unsigned span;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)       op = OP_DENY_ALL;
    else if (roll < 48) op = OP_QUERY;
    else if (roll < 75) op = OP_ALLOW;
    else                op = OP_DENY;
    first = pick_port();
    last  = 16'($urandom());   // don't-care for query and deny-all, still toggled
    if (op == OP_ALLOW || op == OP_DENY) begin
      roll = $urandom_range(0, 19);
      if (roll == 19) begin
        // whole map in one go - costly, so kept rare
        first = 16'h0000;
        last  = 16'hFFFF;
      end else begin
        if (roll < 12)      span = $urandom_range(0, 70);
        else if (roll < 17) span = $urandom_range(0, 600);
        else                span = $urandom_range(0, 8000);
        last = (first + span > 32'hFFFF) ? 16'hFFFF : 16'(first + span);
        // reversed range: map untouched, flagged empty
        if ($urandom_range(0, 9) == 0 && first != last) begin
          swap  = first;
          first = last;
          last  = swap;
        end
      end
      recent_edge = $urandom_range(0, 1) ? first : last;
    end
    send_request(op, first, last);
  endtask

  // Result side: takes transactions, checks them, and stalls at random.
  // Every 40 results it alternates between stalling and running flat out.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int holds_served;
    int taken;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    taken        = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        tracker.check_verdict(out_chan.port_allowed, out_chan.range_empty);
        taken++;
        stall_left = ((taken / 40) % 2 == 1) ? 0 : $urandom_range(0, 17);
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int seg;
    int k;
    in_chan.valid      = 1'b0;
    in_chan.operation  = OP_QUERY;
    in_chan.first_port = '0;
    in_chan.last_port  = '0;
    tx_gaps       = 1'b1;
    hold_requests = 0;
    hot_base      = '0;
    recent_edge   = '0;
    rst_n         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Straight after the clear pass every port is denied.
    send_request(OP_QUERY,    16'h0000, 16'h0000);
    send_request(OP_QUERY,    16'hFFFF, 16'h1234);  // last_port ignored
    send_request(OP_ALLOW,    16'h0000, 16'h0000);  // single port, bottom of map
    send_request(OP_QUERY,    16'h0000, 16'hFFFF);
    send_request(OP_QUERY,    16'h0001, 16'h0000);
    send_request(OP_ALLOW,    16'hFFFF, 16'hFFFF);  // single port, top of map
    send_request(OP_QUERY,    16'hFFFF, 16'h0000);
    send_request(OP_ALLOW,    16'hFFFF, 16'h0000);  // reversed, widest possible
    send_request(OP_DENY,     16'h0001, 16'h0000);  // reversed by one
    send_request(OP_QUERY,    16'h0000, 16'h0000);  // still allowed after that
    send_request(OP_ALLOW,    16'd60,   16'd200);   // straddles word boundaries
    send_request(OP_QUERY,    16'd59,   16'd0);
    send_request(OP_QUERY,    16'd60,   16'd0);
    send_request(OP_QUERY,    16'd200,  16'd0);
    send_request(OP_QUERY,    16'd201,  16'd0);
    send_request(OP_DENY,     16'd128,  16'd128);   // first bit of a word
    send_request(OP_QUERY,    16'd128,  16'd0);
    send_request(OP_QUERY,    16'd127,  16'd0);
    send_request(OP_DENY_ALL, 16'hFFFF, 16'h0000);  // reversed fields, no flag
    send_request(OP_QUERY,    16'd100,  16'd0);
    send_request(OP_ALLOW,    16'h0000, 16'hFFFF);  // whole map
    send_request(OP_QUERY,    16'hAAAA, 16'h5555);
    send_request(OP_DENY,     16'h5555, 16'hAAAA);
    send_request(OP_QUERY,    16'h5554, 16'hFFFF);
    send_request(OP_QUERY,    16'h5555, 16'hFFFF);
    settle();

    // Random part in segments; each moves the hot window and sets the pacing.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      hot_base = 16'($urandom());
      tx_gaps  = (seg % 3 != 1);
      if (seg == 3) begin
        // back-to-back requests against a long result hold-off: the block fills
        // up and must drop in_chan.ready
        tx_gaps = 1'b0;
        hold_requests++;
      end
      if (seg == 6) settle();   // let the pipe run dry mid-run
      for (k = 0; k < SEG_ITEMS; k++) send_random_request();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("PASS io_permission_bitmap");
    else
      $display("FAIL io_permission_bitmap");
    $finish;
  end

endmodule
